// ===== sv/wft_pkg.sv =====
// ----------------------------------------------------------------------------
// wft_pkg
// Shared types and constants for the Wiegand frame transmitter.
// ----------------------------------------------------------------------------
package wft_pkg;

   localparam int TIMER_BITS_DEFAULT = 20;

   localparam int FRAME_BITS      = 34;
   localparam int CARD_BITS       = 32;
   localparam int SHORT_CARD_BITS = 24;
   localparam int COUNT_BITS      = 6;

   localparam logic [COUNT_BITS-1:0] LONG_FRAME_LEN  = 6'd34;
   localparam logic [COUNT_BITS-1:0] SHORT_FRAME_LEN = 6'd26;

   localparam int PULSE_BITS = 16;
   localparam int GAP_BITS   = 20;
   localparam int CSR_BITS   = 20;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [PULSE_BITS-1:0] PULSE_RESET = 16'd100;
   localparam logic [GAP_BITS-1:0]   GAP_RESET   = 20'd1000;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_HIGH = 2'd2;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [CARD_BITS-1:0] card_data;
      logic                 long_format;
   } req_type;

   typedef struct packed {
      logic data0_line;
      logic data1_line;
      logic busy_res;
      logic frame_done;
      logic send_rejected;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] bits;
      logic [COUNT_BITS-1:0] length;
   } frame_type;

endpackage

// ===== sv/wft_frame_build.sv =====
// ----------------------------------------------------------------------------
// wft_frame_build
// Builds a 26- or 34-bit frame with parity, left aligned at bit 33.
// ----------------------------------------------------------------------------
module wft_frame_build (
   input  logic [wft_pkg::CARD_BITS-1:0] card_data,
   input  logic                          long_format,
   output wft_pkg::frame_type            frame
);
   import wft_pkg::*;

   logic [SHORT_CARD_BITS-1:0] short_data;
   logic                       long_even;
   logic                       long_odd;
   logic                       short_even;
   logic                       short_odd;

   assign short_data = card_data[SHORT_CARD_BITS-1:0];

   // long: even over 31..16, odd over 15..0; short: 12/12 split
   assign long_even  = ^card_data[31:16];
   assign long_odd   = ~(^card_data[15:0]);
   assign short_even = ^short_data[23:12];
   assign short_odd  = ~(^short_data[11:0]);

   always_comb begin
      if (long_format) begin
         frame.bits   = {long_even, card_data, long_odd};
         frame.length = LONG_FRAME_LEN;
      end else begin
         frame.bits   = {short_even, short_data, short_odd, 8'h00};
         frame.length = SHORT_FRAME_LEN;
      end
   end

endmodule

// ===== sv/wiegand_frame_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// wiegand_frame_transmitter_top
// Wiegand 26/34-bit transmitter driven by tick and send words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per tick or send request (valid/ready). Each
//   accepted word yields exactly one rsp_* word holding the DATA0/DATA1
//   levels, busy, frame-done and rejected flags after that word is handled.
//   A send while a frame is in progress is rejected and does not advance time.
//   The response sits in an output register the cycle after acceptance.
//   Throughput is one word per cycle while req_ready stays high; the frame
//   state and the output register are updated together on acceptance.
//   If the receiver stalls, the output register holds its word and req_ready
//   drops only while that register is full and not being taken.
//   csr_* writes pulse_ticks, gap_ticks and active_high; write only when idle.
//   Reset (synchronous) restores 100/1000/active-low and an idle frame state.
// ----------------------------------------------------------------------------
module wiegand_frame_transmitter_top #(
   parameter int TIMER_BITS = wft_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wft_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wft_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [wft_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wft_pkg::CSR_BITS-1:0]       csr_wdata
);
   import wft_pkg::*;

   localparam logic [32:0] TIMER_MAX_WIDE = (33'd1 << TIMER_BITS) - 33'd1;
   localparam logic [31:0] TIMER_MAX      = TIMER_MAX_WIDE[31:0];
   localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

   // zero acts as one tick; saturate at the timer width
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [31:0] v);
      logic [31:0] t;
      t = v;
      if (t == 32'd0) t = 32'd1;
      if (t > TIMER_MAX) t = TIMER_MAX;
      return t[TIMER_BITS-1:0];
   endfunction

   logic [PULSE_BITS-1:0] pulse_ticks_ff;
   logic [GAP_BITS-1:0]   gap_ticks_ff;
   logic                  active_high_ff;

   logic [FRAME_BITS-1:0] frame_bits_ff, frame_bits_in;
   logic [COUNT_BITS-1:0] bits_left_ff, bits_left_in;
   logic                  in_pulse_ff, in_pulse_in;
   logic [TIMER_BITS-1:0] ticks_left_ff, ticks_left_in;
   logic                  sending_ff, sending_in;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   frame_type             frame;
   logic                  accept;
   logic                  done;
   logic                  rejected;
   logic [TIMER_BITS-1:0] pulse_load;
   logic [TIMER_BITS-1:0] gap_load;
   logic [TIMER_BITS-1:0] ticks_dec;

   wft_frame_build u_frame (
      .card_data   (req_data.card_data),
      .long_format (req_data.long_format),
      .frame       (frame)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pulse_load = timer_load(32'(pulse_ticks_ff));
   assign gap_load   = timer_load(32'(gap_ticks_ff));
   assign ticks_dec  = (ticks_left_ff != '0) ? ticks_left_ff - TIMER_ONE : ticks_left_ff;

   always_comb begin
      frame_bits_in = frame_bits_ff;
      bits_left_in  = bits_left_ff;
      in_pulse_in   = in_pulse_ff;
      ticks_left_in = ticks_left_ff;
      sending_in    = sending_ff;
      done          = 1'b0;
      rejected      = 1'b0;
      if (req_data.operation == OP_SEND) begin
         if (sending_ff) begin
            rejected = 1'b1;
         end else begin
            frame_bits_in = frame.bits;
            bits_left_in  = frame.length;
            sending_in    = 1'b1;
            in_pulse_in   = 1'b1;
            ticks_left_in = pulse_load;
         end
      end else if (sending_ff) begin
         ticks_left_in = ticks_dec;
         if (ticks_dec == '0) begin
            if (in_pulse_ff) begin
               in_pulse_in   = 1'b0;
               ticks_left_in = gap_load;
            end else begin
               bits_left_in  = (bits_left_ff != '0) ? bits_left_ff - 6'd1 : bits_left_ff;
               frame_bits_in = {frame_bits_ff[FRAME_BITS-2:0], 1'b0};
               if (bits_left_in == '0) begin
                  sending_in    = 1'b0;
                  frame_bits_in = '0;
                  done          = 1'b1;
               end else begin
                  in_pulse_in   = 1'b1;
                  ticks_left_in = pulse_load;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_in.data0_line    = ~active_high_ff;
      rsp_in.data1_line    = ~active_high_ff;
      rsp_in.busy_res      = sending_in;
      rsp_in.frame_done    = done;
      rsp_in.send_rejected = rejected;
      if (sending_in && in_pulse_in) begin
         if (frame_bits_in[FRAME_BITS-1]) rsp_in.data1_line = active_high_ff;
         else                             rsp_in.data0_line = active_high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff <= PULSE_RESET;
         gap_ticks_ff   <= GAP_RESET;
         active_high_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSE_TICKS: pulse_ticks_ff <= csr_wdata[PULSE_BITS-1:0];
            CSR_GAP_TICKS:   gap_ticks_ff   <= csr_wdata[GAP_BITS-1:0];
            CSR_ACTIVE_HIGH: active_high_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff <= '0;
         bits_left_ff  <= '0;
         in_pulse_ff   <= 1'b0;
         ticks_left_ff <= '0;
         sending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            frame_bits_ff <= frame_bits_in;
            bits_left_ff  <= bits_left_in;
            in_pulse_ff   <= in_pulse_in;
            ticks_left_ff <= ticks_left_in;
            sending_ff    <= sending_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> !rsp_ff.busy_res)
      else $error("frame_done with busy set");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_rejected |-> rsp_ff.busy_res)
      else $error("send rejected while idle");

   a_sending_bits: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> bits_left_ff != '0)
      else $error("sending with no bits left");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> frame_bits_ff == '0)
      else $error("idle with frame bits left");

endmodule

// ===== dv/wiegand_frame_transmitter_top_tb.sv =====
// ----------------------------------------------------------------------------
// wiegand_frame_transmitter_top_tb
// Self-checking bench for the Wiegand 26/34-bit frame transmitter.
// A cycle-level predictor tracks the frame shifter and the pulse/gap timer.
// Every response word is compared field by field with the predicted word.
// Stimulus: directed frames at the timing extremes, a level change
// mid-frame, and random frames with stray sends under several settings.
// ----------------------------------------------------------------------------
module wiegand_frame_transmitter_top_tb;
   import wft_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned MAX_PRINTS  = 30;

   typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]       csr_wdata = '0;

   wiegand_frame_transmitter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state and register copy
   logic [PULSE_BITS-1:0] cfg_pulse  = PULSE_RESET;
   logic [GAP_BITS-1:0]   cfg_gap    = GAP_RESET;
   logic                  cfg_active = 1'b0;
   logic [FRAME_BITS-1:0] tx_bits    = '0;
   logic [COUNT_BITS-1:0] tx_left    = '0;
   logic                  tx_in_pulse = 1'b0;
   logic [19:0]           tx_ticks   = '0;
   logic                  tx_sending = 1'b0;

   rsp_type     expected_lines[$];
   rsp_type     want_line;
   int unsigned error_count    = 0;
   int unsigned words_checked  = 0;
   int unsigned frames_done    = 0;
   int unsigned sends_rejected = 0;
   int unsigned words_sent     = 0;
   int unsigned burst_left     = 0;
   int unsigned quiet_cycles   = 0;

   // timing the stimulus side intends, used to size tick runs
   logic [PULSE_BITS-1:0] cur_pulse = PULSE_RESET;
   logic [GAP_BITS-1:0]   cur_gap   = GAP_RESET;

   function automatic logic [19:0] timer_len(input logic [19:0] v);
      return (v == '0) ? 20'd1 : v;
   endfunction

   function automatic rsp_type advance_frame(input req_type w);
      rsp_type          r;
      logic [23:0]      short_card;
      r = '0;
      if (w.operation == OP_SEND) begin
         if (tx_sending) begin
            r.send_rejected = 1'b1;
         end else begin
            if (w.long_format) begin
               tx_bits = {^w.card_data[31:16], w.card_data, ~^w.card_data[15:0]};
               tx_left = LONG_FRAME_LEN;
            end else begin
               short_card = w.card_data[23:0];
               tx_bits = {^short_card[23:12], short_card, ~^short_card[11:0], 8'h00};
               tx_left = SHORT_FRAME_LEN;
            end
            tx_sending  = 1'b1;
            tx_in_pulse = 1'b1;
            tx_ticks    = timer_len({4'h0, cfg_pulse});
         end
      end else if (tx_sending) begin
         if (tx_ticks != '0) tx_ticks = tx_ticks - 20'd1;
         if (tx_ticks == '0) begin
            if (tx_in_pulse) begin
               tx_in_pulse = 1'b0;
               tx_ticks    = timer_len(cfg_gap);
            end else begin
               if (tx_left != '0) tx_left = tx_left - 6'd1;
               tx_bits = tx_bits << 1;
               if (tx_left == '0) begin
                  tx_sending   = 1'b0;
                  tx_bits      = '0;
                  r.frame_done = 1'b1;
               end else begin
                  tx_in_pulse = 1'b1;
                  tx_ticks    = timer_len({4'h0, cfg_pulse});
               end
            end
         end
      end
      r.data0_line = ~cfg_active;
      r.data1_line = ~cfg_active;
      if (tx_sending && tx_in_pulse) begin
         if (tx_bits[FRAME_BITS-1]) r.data1_line = cfg_active;
         else r.data0_line = cfg_active;
      end
      r.busy_res = tx_sending;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS)
         $display("MISMATCH @%0t %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) expected_lines.push_back(advance_frame(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_PULSE_TICKS: cfg_pulse  = csr_wdata[PULSE_BITS-1:0];
               CSR_GAP_TICKS:   cfg_gap    = csr_wdata[GAP_BITS-1:0];
               CSR_ACTIVE_HIGH: cfg_active = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               report_mismatch("response with nothing expected", 32'(rsp_data), '0);
            end else begin
               want_line = expected_lines.pop_front();
               words_checked++;
               if (want_line.frame_done) frames_done++;
               if (want_line.send_rejected) sends_rejected++;
               if (rsp_data.data0_line !== want_line.data0_line)
                  report_mismatch("data0_line", 32'(rsp_data.data0_line),
                                  32'(want_line.data0_line));
               if (rsp_data.data1_line !== want_line.data1_line)
                  report_mismatch("data1_line", 32'(rsp_data.data1_line),
                                  32'(want_line.data1_line));
               if (rsp_data.busy_res !== want_line.busy_res)
                  report_mismatch("busy_res", 32'(rsp_data.busy_res),
                                  32'(want_line.busy_res));
               if (rsp_data.frame_done !== want_line.frame_done)
                  report_mismatch("frame_done", 32'(rsp_data.frame_done),
                                  32'(want_line.frame_done));
               if (rsp_data.send_rejected !== want_line.send_rejected)
                  report_mismatch("send_rejected", 32'(rsp_data.send_rejected),
                                  32'(want_line.send_rejected));
            end
         end
      end
   end

   // receiver: alternates between streaming, random stalls and a sparse pattern
   rx_mode_type rx_mode = RX_STREAM;
   int unsigned rx_left = 0;
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 120);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_STREAM: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         default:   rsp_ready <= (rx_left[1:0] == 2'b00);
      endcase
   end

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // sender: bursts of words separated by random gaps
   task automatic push_word(input req_type w);
      int unsigned idle_gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
         repeat (idle_gap) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // hold off until every response is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_lines.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper write bits carry junk
   task automatic set_timing(input logic [PULSE_BITS-1:0] pulse,
                             input logic [GAP_BITS-1:0] gap, input logic act);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(CSR_PULSE_TICKS, {junk[3:0], pulse});
      write_reg(CSR_GAP_TICKS, gap);
      write_reg(CSR_ACTIVE_HIGH, {junk[31:13], act});
      cur_pulse = pulse;
      cur_gap   = gap;
   endtask

   function automatic req_type tick_word();
      req_type w;
      w.operation   = OP_TICK;
      w.card_data   = $urandom;
      w.long_format = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic req_type send_word(input logic [31:0] card, input logic long_fmt);
      req_type w;
      w.operation   = OP_SEND;
      w.card_data   = card;
      w.long_format = long_fmt;
      return w;
   endfunction

   function automatic int unsigned frame_ticks(input logic long_fmt);
      return (long_fmt ? 34 : 26) * (timer_len({4'h0, cur_pulse}) + timer_len(cur_gap));
   endfunction

   // ticks, with stray sends mixed in at junk_pct percent (they do not advance time)
   task automatic run_ticks(input int unsigned n, input int unsigned junk_pct);
      repeat (n) begin
         if ($urandom_range(0, 99) < junk_pct)
            push_word(send_word($urandom, 1'($urandom_range(0, 1))));
         if ($urandom_range(0, 199) == 0) drain();
         push_word(tick_word());
      end
   endtask

   task automatic test_idle_ticks();
      run_ticks(4, 0);
   endtask

   task automatic test_zero_timing_short_frame();
      drain();
      set_timing('0, '0, 1'b1);
      write_reg(CSR_UNUSED, CSR_BITS'($urandom));
      push_word(send_word(32'hFFFF_FFFF, 1'b0));
      run_ticks(5, 0);
      push_word(send_word(32'h0, 1'b1));     // busy, must be rejected
      run_ticks(frame_ticks(1'b0) - 5, 0);
      run_ticks(2, 0);
   endtask

   task automatic test_long_frame();
      drain();
      set_timing(16'd1, 20'd2, 1'b0);
      push_word(send_word(32'h0, 1'b1));
      run_ticks(frame_ticks(1'b1), 10);
      run_ticks(2, 0);
   endtask

   task automatic test_level_switch();
      int unsigned total;
      drain();
      set_timing(16'd1, 20'd1, 1'b1);
      total = frame_ticks(1'b0);
      push_word(send_word($urandom, 1'b0));
      run_ticks(9, 0);
      drain();
      write_reg(CSR_ACTIVE_HIGH, '0);         // flips polarity mid-frame
      run_ticks(total - 9, 0);
   endtask

   task automatic test_random_frames();
      int unsigned target;
      logic        long_fmt;
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         if (ph == 5)
            set_timing(PULSE_BITS'($urandom_range(4, 6)), GAP_BITS'($urandom_range(3, 5)),
                       1'($urandom_range(0, 1)));
         else
            set_timing(PULSE_BITS'($urandom_range(0, 2)), GAP_BITS'($urandom_range(0, 2)),
                       1'($urandom_range(0, 1)));
         target = words_sent + ((ph == 5) ? 1 : 40);
         while (words_sent < target) begin
            long_fmt = 1'($urandom_range(0, 1));
            push_word(send_word($urandom, long_fmt));
            run_ticks(frame_ticks(long_fmt), 4);
            run_ticks($urandom_range(0, 6), 0);
         end
      end
   endtask

   // slowest settings; the frame is left running at the end
   task automatic test_slowest_timing();
      drain();
      set_timing(16'hFFFF, 20'hF_FFFF, 1'b1);
      push_word(send_word($urandom, 1'b1));
      run_ticks(60, 8);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_zero_timing_short_frame();
      test_long_frame();
      test_level_switch();
      test_random_frames();
      test_slowest_timing();
      drain();
      $display("Checked %0d response words: %0d frames completed, %0d sends rejected.",
               words_checked, frames_done, sends_rejected);
      $display("Settings ran from zero-length to maximum pulse and gap, both polarities.");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
